### hdl/assert_macros.svh
// Assertion macros for the checker file of the sketch block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_SAME(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cmshh_pkg.sv
// Package: types, constants and hash step for the count-min sketch block
`timescale 1ns / 1ps

package cmshh_pkg;

  localparam int ROWS    = 4;
  localparam int COLUMNS = 1024;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int DATA_W = 32;
  localparam int PCT_W  = 7;
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PROD_W = DATA_W + PCT_W;

  localparam logic [DATA_W-1:0] SEED_BASE = 32'h1234_5678;
  localparam logic [DATA_W-1:0] SEED_STEP = 32'h8765_4321;
  localparam logic [DATA_W-1:0] CRC_POLY  = 32'h82F6_3B78;
  localparam logic [PCT_W-1:0]  PCT_SCALE = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_RESET = 7'd10;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_HEAVY = 2'd2;
  localparam logic [1:0] OP_DECAY = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] amount;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] estimate;
    logic              is_heavy;
    logic [DATA_W-1:0] window_total;
  } rsp_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } store_wr_t;

  function automatic logic [DATA_W-1:0] crc_byte(input logic [DATA_W-1:0] c);
    logic [DATA_W-1:0] v;
    v = c;
    for (int b = 0; b < 8; b++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

### hdl/cmshh_store.sv
// Counter store: one write port, one registered read port
`timescale 1ns / 1ps

module cmshh_store import cmshh_pkg::*; (
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/count_min_sketch_heavy_hitter_core.sv
// Top level: count-min sketch with heavy-hitter check and window decay
//
// Requests enter on cmd and are taken at a clock edge with start high and
// busy low. Each request gives one result on result, marked by done for a
// single cycle; the receiver cannot stall, so done is never held.
// cfg_wen writes cfg_wdata into the heavy-hitter percentage (reset 10);
// write it only while the block is idle.
// Add, query and heavy check walk the rows one at a time through the single
// counter store: per row the byte-wise CRC32C hash (S_HASH), one read
// (S_READ), one update or write-back (S_UPD); then S_MUL forms the
// heavy-hitter products and S_OUT gives the result and done. A new
// request is taken only once busy falls back low in S_IDLE.
// Decay sweeps every counter through the store read and write ports, one a
// cycle; done rises once the sweep has covered every counter.
// After reset the store is cleared, one counter a cycle, with busy high until
// every counter is cleared; configuration writes are taken meanwhile.
// Column index is the CRC modulo COLUMNS, which must be a power of two.
`timescale 1ns / 1ps

module count_min_sketch_heavy_hitter_core import cmshh_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cmd_t             cmd,
  output logic             done,
  output rsp_t             result,
  input  logic             cfg_wen,
  input  logic [PCT_W-1:0] cfg_wdata
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_DECAY = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]        state;
  logic [1:0]        op;
  logic [DATA_W-1:0] key;
  logic [DATA_W-1:0] amount;
  logic [DATA_W-1:0] crc;
  logic [DATA_W-1:0] seed;
  logic [1:0]        step;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] row_base;
  logic [DATA_W-1:0] lowest;
  logic [DATA_W-1:0] window;
  logic [PCT_W-1:0]  hp;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;
  logic [ADDR_W:0]   sweep;
  logic              dec_wr;
  logic [ADDR_W-1:0] dec_addr;

  logic [DATA_W-1:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] upd;
  logic [DATA_W-1:0] seed_next;
  store_wr_t         wr;

  cmshh_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy      = (state != S_IDLE);
  assign addr      = row_base + ADDR_W'(crc[COL_W-1:0]);
  assign upd       = rdata + ((op == OP_ADD) ? amount : '0);
  assign seed_next = seed + SEED_STEP;

  always_comb begin
    wr    = '0;
    raddr = addr;
    case (state)
      S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = sweep[ADDR_W-1:0];
      end
      S_UPD: begin
        if (op == OP_ADD) begin
          wr.en   = 1'b1;
          wr.addr = addr;
          wr.data = upd;
        end
      end
      S_DECAY: begin
        raddr = sweep[ADDR_W-1:0];
        if (dec_wr) begin
          wr.en   = 1'b1;
          wr.addr = dec_addr;
          wr.data = rdata >> 1;
        end
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      sweep  <= '0;
      done   <= 1'b0;
      hp     <= PCT_RESET;
      window <= '0;
      dec_wr <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wen) begin
        hp <= cfg_wdata;
      end
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep[ADDR_W-1:0] == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op     <= cmd.operation;
            key    <= cmd.key;
            amount <= cmd.amount;
            lowest <= '1;
            if (cmd.operation == OP_DECAY) begin
              sweep  <= '0;
              dec_wr <= 1'b0;
              state  <= S_DECAY;
            end else begin
              row      <= '0;
              row_base <= '0;
              seed     <= SEED_BASE;
              crc      <= SEED_BASE ^ cmd.key;
              step     <= '0;
              state    <= S_HASH;
            end
          end
        end
        S_HASH: begin
          crc  <= crc_byte(crc);
          step <= step + 1'b1;
          if (step == 2'd3) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (upd < lowest) begin
            lowest <= upd;
          end
          if (row == ROW_W'(ROWS - 1)) begin
            state <= S_MUL;
          end else begin
            row      <= row + 1'b1;
            row_base <= row_base + ADDR_W'(COLUMNS);
            seed     <= seed_next;
            crc      <= seed_next ^ key;
            step     <= '0;
            state    <= S_HASH;
          end
        end
        S_MUL: begin
          lhs <= PROD_W'(lowest) * PROD_W'(PCT_SCALE);
          rhs <= PROD_W'(hp) * PROD_W'(window);
          if (op == OP_ADD) begin
            window <= window + amount;
          end
          state <= S_OUT;
        end
        S_DECAY: begin
          if (sweep == (ADDR_W + 1)'(CELLS)) begin
            dec_wr <= 1'b0;
            window <= '0;
            state  <= S_OUT;
          end else begin
            dec_wr   <= 1'b1;
            dec_addr <= sweep[ADDR_W-1:0];
            sweep    <= sweep + 1'b1;
          end
        end
        S_OUT: begin
          result.estimate     <= (op == OP_DECAY) ? '0 : lowest;
          result.is_heavy     <= (op == OP_HEAVY) && (window != '0) && (lhs >= rhs);
          result.window_total <= window;
          done                <= 1'b1;
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/cmshh_checker.sv
// Port checker for the sketch block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmshh_checker import cmshh_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input rsp_t             result
);

  `ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result shown while busy")
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "request taken but not busy")
  `ASSERT_NEXT(a_accept_nodone, clk, rst, start && !busy, !done, "result one cycle after request")
  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe longer than one cycle")
  `ASSERT_SAME(a_heavy_window, clk, rst, done && result.is_heavy, result.window_total != '0, "heavy hitter reported on empty window")

endmodule

bind count_min_sketch_heavy_hitter_core cmshh_checker u_chk (.*);
